@@ sv/lgvs_pkg.sv @@
// shared types and constants for the linear gradient vertex shader
`default_nettype none

package lgvs_pkg;

  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NUM_CH    = 4;
  localparam int unsigned ALPHA_LSB = 24;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X     = 3'd0,
    CFG_START_Y     = 3'd1,
    CFG_END_X       = 3'd2,
    CFG_END_Y       = 3'd3,
    CFG_START_COLOR = 3'd4,
    CFG_END_COLOR   = 3'd5,
    CFG_BLEND_ALPHA = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_DIV  = 2'd2
  } cls_e;

  typedef struct packed {
    logic [BYTE_W-1:0] alpha;
    logic              last;
  } side_t;

  typedef struct packed {
    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] end_color;
    logic               blend_alpha;
  } cfg_color_t;

endpackage

`default_nettype wire

@@ sv/lgvs_proj.sv @@
// projection front end: offsets, products, dot product, squared length and range class
`default_nettype none

module lgvs_proj #(
  parameter int unsigned POS_WIDTH = 16,
  localparam int unsigned DW  = POS_WIDTH + 1,
  localparam int unsigned PRW = 2 * DW,
  localparam int unsigned LW  = 2 * POS_WIDTH + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [POS_WIDTH-1:0] start_x_i,
  input  logic signed [POS_WIDTH-1:0] start_y_i,
  input  logic signed [POS_WIDTH-1:0] end_x_i,
  input  logic signed [POS_WIDTH-1:0] end_y_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [POS_WIDTH-1:0] pos_x_i,
  input  logic signed [POS_WIDTH-1:0] pos_y_i,
  input  lgvs_pkg::side_t             side_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lgvs_pkg::cls_e              cls_o,
  output logic [LW-1:0]               rem_o,
  output logic [LW-1:0]               len2_o,
  output lgvs_pkg::side_t             side_o
);

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  logic signed [DW-1:0] px_d, py_d, dx_d, dy_d;
  logic signed [DW-1:0] px_q, py_q, dx_q, dy_q;
  lgvs_pkg::side_t      s1_q, s2_q, s3_q;

  logic signed [PRW-1:0] p1_q, p2_q, q1_q, q2_q;

  logic signed [PRW:0]   dot;
  logic [LW-1:0]         len2;
  lgvs_pkg::cls_e        cls_d, cls_q;
  logic [LW-1:0]         rem_q, len2_q;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  // offsets from the segment start
  assign px_d = DW'(pos_x_i) - DW'(start_x_i);
  assign py_d = DW'(pos_y_i) - DW'(start_y_i);
  assign dx_d = DW'(end_x_i) - DW'(start_x_i);
  assign dy_d = DW'(end_y_i) - DW'(start_y_i);

  // dot product, squared length and range class
  assign dot  = (PRW+1)'(p1_q) + (PRW+1)'(p2_q);
  assign len2 = LW'(q1_q) + LW'(q2_q);

  always_comb begin
    priority if (dot[PRW] || dot == '0 || len2 == '0) begin
      cls_d = lgvs_pkg::CLS_ZERO;
    end else if (dot >= $signed((PRW+1)'(len2))) begin
      cls_d = lgvs_pkg::CLS_ONE;
    end else begin
      cls_d = lgvs_pkg::CLS_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      px_q <= px_d;
      py_q <= py_d;
      dx_q <= dx_d;
      dy_q <= dy_d;
      s1_q <= side_i;
    end
    if (en2) begin
      p1_q <= PRW'(px_q) * PRW'(dx_q);
      p2_q <= PRW'(py_q) * PRW'(dy_q);
      q1_q <= PRW'(dx_q) * PRW'(dx_q);
      q2_q <= PRW'(dy_q) * PRW'(dy_q);
      s2_q <= s1_q;
    end
    if (en3) begin
      cls_q  <= cls_d;
      rem_q  <= dot[LW-1:0];
      len2_q <= len2;
      s3_q   <= s2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign cls_o       = cls_q;
  assign rem_o       = rem_q;
  assign len2_o      = len2_q;
  assign side_o      = s3_q;

endmodule

`default_nettype wire

@@ sv/lgvs_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module lgvs_div #(
  parameter int unsigned T_FRAC_BITS = 8,
  parameter int unsigned LW = 33,
  localparam int unsigned TW = T_FRAC_BITS + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lgvs_pkg::cls_e  cls_i,
  input  logic [LW-1:0]   rem_i,
  input  logic [LW-1:0]   len2_i,
  input  lgvs_pkg::side_t side_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [TW-1:0]   t_o,
  output lgvs_pkg::side_t side_o
);

  localparam int unsigned NS = T_FRAC_BITS;

  logic                   en   [NS+1];
  logic                   v_q  [NS];
  lgvs_pkg::cls_e         cls_q[NS];
  logic [LW-1:0]          rem_q[NS];
  logic [LW-1:0]          len_q[NS];
  logic [NS-1:0]          quo_q[NS];
  lgvs_pkg::side_t        sd_q [NS];

  logic                   v_s  [NS+1];
  lgvs_pkg::cls_e         cls_s[NS+1];
  logic [LW-1:0]          rem_s[NS+1];
  logic [LW-1:0]          len_s[NS+1];
  logic [NS-1:0]          quo_s[NS+1];
  lgvs_pkg::side_t        sd_s [NS+1];

  assign v_s[0]   = in_valid_i;
  assign cls_s[0] = cls_i;
  assign rem_s[0] = rem_i;
  assign len_s[0] = len2_i;
  assign quo_s[0] = '0;
  assign sd_s[0]  = side_i;
  assign en[NS]   = out_ready_i;
  assign in_ready_o = en[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [LW:0] sh, diff;
    logic        ge;

    assign sh   = {rem_s[k], 1'b0};
    assign ge   = sh >= {1'b0, len_s[k]};
    assign diff = sh - {1'b0, len_s[k]};
    assign en[k] = !v_q[k] || en[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        cls_q[k] <= cls_s[k];
        rem_q[k] <= ge ? diff[LW-1:0] : sh[LW-1:0];
        len_q[k] <= len_s[k];
        quo_q[k] <= {quo_s[k][NS-2:0], ge};
        sd_q[k]  <= sd_s[k];
      end
    end

    assign v_s[k+1]   = v_q[k];
    assign cls_s[k+1] = cls_q[k];
    assign rem_s[k+1] = rem_q[k];
    assign len_s[k+1] = len_q[k];
    assign quo_s[k+1] = quo_q[k];
    assign sd_s[k+1]  = sd_q[k];
  end

  always_comb begin
    unique case (cls_s[NS])
      lgvs_pkg::CLS_ONE:  t_o = TW'(1) << T_FRAC_BITS;
      lgvs_pkg::CLS_DIV:  t_o = {1'b0, quo_s[NS]};
      lgvs_pkg::CLS_ZERO: t_o = '0;
      default:            t_o = '0;
    endcase
  end

  assign out_valid_o = v_s[NS];
  assign side_o      = sd_s[NS];

  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && cls_q[NS-1] == lgvs_pkg::CLS_DIV |-> rem_q[NS-1] < len_q[NS-1])
    else $error("divider remainder not below divisor");

  a_div_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && cls_q[0] == lgvs_pkg::CLS_DIV |-> len_q[0] != '0)
    else $error("division started with zero length");

endmodule

`default_nettype wire

@@ sv/lgvs_blend.sv @@
// color blend stages and output register
`default_nettype none

module lgvs_blend #(
  parameter int unsigned T_FRAC_BITS = 8,
  localparam int unsigned TW  = T_FRAC_BITS + 1,
  localparam int unsigned PBW = T_FRAC_BITS + 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lgvs_pkg::cfg_color_t                cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [TW-1:0]                       t_i,
  input  lgvs_pkg::side_t                     side_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lgvs_pkg::COLOR_W-1:0]        color_o,
  output logic [TW-1:0]                       t_o,
  output logic                                last_o
);

  localparam int unsigned BW = lgvs_pkg::BYTE_W;
  localparam int unsigned NC = lgvs_pkg::NUM_CH;

  logic en1, en2;
  logic v1_q, v2_q;

  logic signed [PBW-1:0]          prod_d [NC];
  logic signed [PBW-1:0]          prod_q [NC];
  logic [PBW-1:0]                 sum    [NC];
  logic [BW-1:0]                  chan   [NC];
  logic [TW-1:0]                  t1_q, t2_q;
  lgvs_pkg::side_t                s1_q;
  logic [lgvs_pkg::COLOR_W-1:0]   color_d, color_q;
  logic                           last_q;

  assign en2 = !v2_q || out_ready_i;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  for (genvar c = 0; c < NC; c++) begin : g_ch
    logic [BW-1:0]       c0, c1;
    logic signed [BW:0]  delta;

    assign c0    = cfg_i.start_color[c*BW +: BW];
    assign c1    = cfg_i.end_color[c*BW +: BW];
    assign delta = $signed({1'b0, c1}) - $signed({1'b0, c0});
    assign prod_d[c] = PBW'(delta) * PBW'($signed({1'b0, t_i}));
    assign sum[c]    = PBW'({c0, T_FRAC_BITS'(0)}) + prod_q[c];
    assign chan[c]   = sum[c][T_FRAC_BITS +: BW];
  end

  always_comb begin
    color_d = {chan[2], chan[1], chan[0]} |
              (lgvs_pkg::COLOR_W'(cfg_i.blend_alpha ? chan[3] : s1_q.alpha)
               << lgvs_pkg::ALPHA_LSB);
    color_d[lgvs_pkg::COLOR_W-1:3*BW] = cfg_i.blend_alpha ? chan[3] : s1_q.alpha;
    color_d[3*BW-1:0] = {chan[2], chan[1], chan[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      prod_q <= prod_d;
      t1_q   <= t_i;
      s1_q   <= side_i;
    end
    if (en2) begin
      color_q <= color_d;
      t2_q    <= t1_q;
      last_q  <= s1_q.last;
    end
  end

  assign out_valid_o = v2_q;
  assign color_o     = color_q;
  assign t_o         = t2_q;
  assign last_o      = last_q;

  a_zero_t_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && t2_q == '0 |-> color_q[3*BW-1:0] == cfg_i.start_color[3*BW-1:0])
    else $error("t of zero does not give start color");

  a_one_t_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && t2_q == (TW'(1) << T_FRAC_BITS) |->
      color_q[3*BW-1:0] == cfg_i.end_color[3*BW-1:0])
    else $error("t of one does not give end color");

endmodule

`default_nettype wire

@@ sv/linear_gradient_vertex_shade.sv @@
// linear gradient vertex shader top level with configuration registers
//
// Vertices enter on the in channel (in_valid_i / in_stall_o) with position,
// color and a last flag; one shaded vertex leaves on the out channel
// (out_valid_o / out_stall_i) for every vertex taken, in order.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_wdata_i
// while no vertex is in flight: a rule on the user, not enforced by the
// block. Indexes past the register list are ignored. Three projection
// stages (offsets, four multipliers, sum and range check), one divider
// stage per fraction bit of t, then a blend multiplier stage and the
// output register. One vertex per cycle while out_stall_i is low; each
// stage holds one vertex. Reset clears the configuration registers to zero
// and empties every stage. When the receiver stalls, the output beat holds
// and stages fill from the back; in_stall_o rises only once every stage is
// occupied, and nothing is lost or repeated.
`default_nettype none

module linear_gradient_vertex_shade #(
  parameter int unsigned POS_WIDTH   = 16,
  parameter int unsigned T_FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lgvs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lgvs_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [POS_WIDTH-1:0]         pos_x_i,
  input  logic signed [POS_WIDTH-1:0]         pos_y_i,
  input  logic [lgvs_pkg::COLOR_W-1:0]        vertex_color_i,
  input  logic                                last_vertex_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lgvs_pkg::COLOR_W-1:0]        shaded_color_o,
  output logic [T_FRAC_BITS:0]                blend_factor_o,
  output logic                                last_out_o
);

  localparam int unsigned LW = 2 * POS_WIDTH + 1;
  localparam int unsigned TW = T_FRAC_BITS + 1;

  logic signed [POS_WIDTH-1:0]  start_x_q, start_y_q, end_x_q, end_y_q;
  logic [lgvs_pkg::COLOR_W-1:0] start_color_q, end_color_q;
  logic                         blend_alpha_q;
  lgvs_pkg::cfg_color_t         cfg_color;

  lgvs_pkg::side_t side_in, side_pd, side_db;
  logic            in_ready;
  logic            pd_valid, pd_ready;
  lgvs_pkg::cls_e  pd_cls;
  logic [LW-1:0]   pd_rem, pd_len2;
  logic            db_valid, db_ready;
  logic [TW-1:0]   db_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q     <= '0;
      start_y_q     <= '0;
      end_x_q       <= '0;
      end_y_q       <= '0;
      start_color_q <= '0;
      end_color_q   <= '0;
      blend_alpha_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (lgvs_pkg::cfg_idx_e'(cfg_index_i))
        lgvs_pkg::CFG_START_X:     start_x_q     <= cfg_wdata_i[POS_WIDTH-1:0];
        lgvs_pkg::CFG_START_Y:     start_y_q     <= cfg_wdata_i[POS_WIDTH-1:0];
        lgvs_pkg::CFG_END_X:       end_x_q       <= cfg_wdata_i[POS_WIDTH-1:0];
        lgvs_pkg::CFG_END_Y:       end_y_q       <= cfg_wdata_i[POS_WIDTH-1:0];
        lgvs_pkg::CFG_START_COLOR: start_color_q <= cfg_wdata_i[lgvs_pkg::COLOR_W-1:0];
        lgvs_pkg::CFG_END_COLOR:   end_color_q   <= cfg_wdata_i[lgvs_pkg::COLOR_W-1:0];
        lgvs_pkg::CFG_BLEND_ALPHA: blend_alpha_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_color.start_color = start_color_q;
  assign cfg_color.end_color   = end_color_q;
  assign cfg_color.blend_alpha = blend_alpha_q;

  assign side_in.alpha = vertex_color_i[lgvs_pkg::ALPHA_LSB +: lgvs_pkg::BYTE_W];
  assign side_in.last  = last_vertex_i;

  lgvs_proj #(
    .POS_WIDTH (POS_WIDTH)
  ) u_proj (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_x_i   (start_x_q),
    .start_y_i   (start_y_q),
    .end_x_i     (end_x_q),
    .end_y_i     (end_y_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .side_i      (side_in),
    .out_valid_o (pd_valid),
    .out_ready_i (pd_ready),
    .cls_o       (pd_cls),
    .rem_o       (pd_rem),
    .len2_o      (pd_len2),
    .side_o      (side_pd)
  );

  lgvs_div #(
    .T_FRAC_BITS (T_FRAC_BITS),
    .LW          (LW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pd_valid),
    .in_ready_o  (pd_ready),
    .cls_i       (pd_cls),
    .rem_i       (pd_rem),
    .len2_i      (pd_len2),
    .side_i      (side_pd),
    .out_valid_o (db_valid),
    .out_ready_i (db_ready),
    .t_o         (db_t),
    .side_o      (side_db)
  );

  lgvs_blend #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_color),
    .in_valid_i  (db_valid),
    .in_ready_o  (db_ready),
    .t_i         (db_t),
    .side_i      (side_db),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .color_o     (shaded_color_o),
    .t_o         (blend_factor_o),
    .last_o      (last_out_o)
  );

  assign in_stall_o = !in_ready;

  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output side is free");

  a_factor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> blend_factor_o <= (TW'(1) << T_FRAC_BITS))
    else $error("blend factor above one");

endmodule

`default_nettype wire

@@ verif/gradient_shade_checker.sv @@
// checker for the gradient shader: tracks registers, predicts each shaded vertex, compares beats
module gradient_shade_checker #(
  parameter int unsigned POS_W  = 16,
  parameter int unsigned T_FRAC = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lgvs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lgvs_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic signed [POS_W-1:0]            pos_x_i,
  input  logic signed [POS_W-1:0]            pos_y_i,
  input  logic [lgvs_pkg::COLOR_W-1:0]       vertex_color_i,
  input  logic                               last_vertex_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [lgvs_pkg::COLOR_W-1:0]       shaded_color_i,
  input  logic [T_FRAC:0]                    blend_factor_i,
  input  logic                               last_out_i,
  output int unsigned                        fail_cnt_o,
  output int unsigned                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int T_ONE = 1 << T_FRAC;

  typedef struct packed {
    logic [lgvs_pkg::COLOR_W-1:0] color;
    logic [T_FRAC:0]              factor;
    logic                         last;
  } shade_t;

  logic signed [POS_W-1:0]      start_x, start_y, end_x, end_y;
  logic [lgvs_pkg::COLOR_W-1:0] start_color, end_color;
  logic                         blend_alpha;

  shade_t shade_q[$];
  shade_t want;

  function automatic logic [7:0] mix_channel(input logic [7:0] c0, input logic [7:0] c1,
                                             input int t);
    int acc;
    acc = c0;
    acc = acc * T_ONE + (int'(c1) - int'(c0)) * t;
    return 8'(acc >>> T_FRAC);
  endfunction

  function automatic shade_t shade_vertex(input logic signed [POS_W-1:0] x,
                                          input logic signed [POS_W-1:0] y,
                                          input logic [lgvs_pkg::COLOR_W-1:0] vcol,
                                          input logic last);
    longint ox, oy, dx, dy, px, py, dot, len2;
    int t;
    int ch;
    shade_t r;
    ox = start_x;
    oy = start_y;
    dx = end_x;
    dy = end_y;
    px = x;
    py = y;
    dx = dx - ox;
    dy = dy - oy;
    px = px - ox;
    py = py - oy;
    dot = px * dx + py * dy;
    len2 = dx * dx + dy * dy;
    if (dot <= 0 || len2 == 0) begin
      t = 0;
    end else if (dot >= len2) begin
      t = T_ONE;
    end else begin
      t = int'((dot <<< T_FRAC) / len2);
    end
    for (ch = 0; ch < 3; ch++) begin
      r.color[8*ch +: 8] = mix_channel(start_color[8*ch +: 8], end_color[8*ch +: 8], t);
    end
    if (blend_alpha) begin
      r.color[31:24] = mix_channel(start_color[31:24], end_color[31:24], t);
    end else begin
      r.color[31:24] = vcol[31:24];
    end
    r.factor = (T_FRAC+1)'(t);
    r.last   = last;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x     = '0;
      start_y     = '0;
      end_x       = '0;
      end_y       = '0;
      start_color = '0;
      end_color   = '0;
      blend_alpha = 1'b0;
      shade_q.delete();
      fail_cnt_o  = 0;
      pending_o   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (shade_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10) begin
            $display("unexpected shaded beat: color %h factor %0d last %0b",
                     shaded_color_i, blend_factor_i, last_out_i);
          end
        end else begin
          want = shade_q.pop_front();
          if (want.color !== shaded_color_i || want.factor !== blend_factor_i ||
              want.last !== last_out_i) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10) begin
              $display("mismatch: expected color %h factor %0d last %0b got %h %0d %0b",
                       want.color, want.factor, want.last,
                       shaded_color_i, blend_factor_i, last_out_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        shade_q = {shade_q, shade_vertex(pos_x_i, pos_y_i, vertex_color_i, last_vertex_i)};
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          lgvs_pkg::CFG_START_X:     start_x     = cfg_wdata_i[POS_W-1:0];
          lgvs_pkg::CFG_START_Y:     start_y     = cfg_wdata_i[POS_W-1:0];
          lgvs_pkg::CFG_END_X:       end_x       = cfg_wdata_i[POS_W-1:0];
          lgvs_pkg::CFG_END_Y:       end_y       = cfg_wdata_i[POS_W-1:0];
          lgvs_pkg::CFG_START_COLOR: start_color = cfg_wdata_i[lgvs_pkg::COLOR_W-1:0];
          lgvs_pkg::CFG_END_COLOR:   end_color   = cfg_wdata_i[lgvs_pkg::COLOR_W-1:0];
          lgvs_pkg::CFG_BLEND_ALPHA: blend_alpha = cfg_wdata_i[0];
          default: ;
        endcase
      end
      pending_o = shade_q.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// testbench top for the gradient shader: reset, register phases, vertex stimulus and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_W        = 16;
  localparam int T_FRAC       = 8;
  localparam int LATENCY      = T_FRAC + 5;
  localparam int HOLD_CYCLES  = 120;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 190;
  localparam logic [lgvs_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [lgvs_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [lgvs_pkg::CFG_W-1:0]         cfg_wdata = '0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic signed [POS_W-1:0]            pos_x = '0;
  logic signed [POS_W-1:0]            pos_y = '0;
  logic [lgvs_pkg::COLOR_W-1:0]       vertex_color = '0;
  logic                               last_vertex = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [lgvs_pkg::COLOR_W-1:0]       shaded_color;
  logic [T_FRAC:0]                    blend_factor;
  logic                               last_out;

  int unsigned fail_cnt;
  int unsigned pending;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_req = 1'b0;
  int quiet = 0;
  int cur_sx, cur_sy, cur_ex, cur_ey;

  always #4 clk = ~clk;

  linear_gradient_vertex_shade #(
    .POS_WIDTH   (POS_W),
    .T_FRAC_BITS (T_FRAC)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .vertex_color_i (vertex_color),
    .last_vertex_i  (last_vertex),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .shaded_color_o (shaded_color),
    .blend_factor_o (blend_factor),
    .last_out_o     (last_out)
  );

  gradient_shade_checker #(
    .POS_W  (POS_W),
    .T_FRAC (T_FRAC)
  ) shade_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .vertex_color_i (vertex_color),
    .last_vertex_i  (last_vertex),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .shaded_color_i (shaded_color),
    .blend_factor_i (blend_factor),
    .last_out_i     (last_out),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending)
  );

  function automatic int clamp_pos(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_span(input int lo, input int hi);
    int v;
    v = $urandom_range(0, hi - lo);
    return v + lo;
  endfunction

  task automatic cfg_write(input logic [lgvs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lgvs_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // upper write bits carry junk, only the register width counts
  task automatic program_gradient(input int sx, input int sy, input int ex, input int ey,
                                  input logic [31:0] sc, input logic [31:0] ec,
                                  input logic ba);
    cur_sx = sx;
    cur_sy = sy;
    cur_ex = ex;
    cur_ey = ey;
    cfg_write(lgvs_pkg::CFG_START_X, {16'($urandom), 16'(sx)});
    cfg_write(lgvs_pkg::CFG_START_Y, {16'($urandom), 16'(sy)});
    cfg_write(lgvs_pkg::CFG_END_X, {16'($urandom), 16'(ex)});
    cfg_write(lgvs_pkg::CFG_END_Y, {16'($urandom), 16'(ey)});
    cfg_write(lgvs_pkg::CFG_START_COLOR, sc);
    cfg_write(lgvs_pkg::CFG_END_COLOR, ec);
    cfg_write(lgvs_pkg::CFG_BLEND_ALPHA, {31'($urandom), ba});
    cfg_write(CFG_UNUSED_IDX, $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic random_gradient();
    int sx, sy, ex, ey, kind;
    kind = $urandom_range(0, 7);
    sx = rand_span(-32768, 32767);
    sy = rand_span(-32768, 32767);
    if (kind <= 2) begin
      ex = rand_span(-32768, 32767);
      ey = rand_span(-32768, 32767);
    end else if (kind <= 4) begin
      ex = clamp_pos(sx + rand_span(-2000, 2000));
      ey = clamp_pos(sy + rand_span(-2000, 2000));
    end else if (kind <= 6) begin
      ex = clamp_pos(sx + rand_span(-8, 8));
      ey = clamp_pos(sy + rand_span(-8, 8));
    end else begin
      ex = sx;
      ey = sy;
    end
    program_gradient(sx, sy, ex, ey, $urandom, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_vertex(input int x, input int y, input logic [31:0] c, input logic l);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    pos_x        <= 16'(x);
    pos_y        <= 16'(y);
    vertex_color <= c;
    last_vertex  <= l;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // most vertices land around the segment so t covers the divide range
  task automatic random_vertex();
    int f, x, y;
    logic [31:0] c;
    if ($urandom_range(0, 9) < 7) begin
      f = rand_span(-64, 320);
      x = clamp_pos(cur_sx + ((cur_ex - cur_sx) * f) / 256 + rand_span(-8, 8));
      y = clamp_pos(cur_sy + ((cur_ey - cur_sy) * f) / 256 + rand_span(-8, 8));
    end else begin
      x = rand_span(-32768, 32767);
      y = rand_span(-32768, 32767);
    end
    case ($urandom_range(0, 15))
      0:       c = '0;
      1:       c = '1;
      default: c = $urandom;
    endcase
    send_vertex(x, y, c, 1'($urandom_range(0, 3) == 0));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        int n;
        n = rx_idle ? $urandom_range(0, 7) : 0;
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ordinary segment: ends, middle, beyond both ends, corners
    program_gradient(-1600, -800, 2400, 1600, 32'hC020F010, 32'h40E010F0, 1'b0);
    send_vertex(-1600, -800, 32'h7F123456, 1'b0);
    send_vertex(2400, 1600, 32'hFFFFFFFF, 1'b1);
    send_vertex(400, 400, 32'h00000000, 1'b0);
    send_vertex(-32768, -32768, 32'h12345678, 1'b0);
    send_vertex(32767, 32767, 32'h87654321, 1'b1);
    send_vertex(-32768, 32767, 32'hDEADBEEF, 1'b0);
    send_vertex(32767, -32768, 32'h01020304, 1'b0);
    send_vertex(2399, 1599, 32'hA5A5A5A5, 1'b0);
    send_vertex(-1599, -800, 32'h5A5A5A5A, 1'b0);
    send_vertex(0, 0, 32'hAA55AA55, 1'b1);
    wait_drained();

    // zero-length segment
    program_gradient(123, -456, 123, -456, 32'h11223344, 32'hFFEEDDCC, 1'b1);
    send_vertex(123, -456, 32'hFFFFFFFF, 1'b0);
    send_vertex(32767, -32768, 32'h00000000, 1'b0);
    send_vertex(-32768, 32767, 32'h80808080, 1'b1);
    wait_drained();

    // widest segments, exact wide products
    program_gradient(-32768, -32768, 32767, 32767, 32'hFF00FF00, 32'h00FF00FF, 1'b1);
    send_vertex(-32768, -32768, 32'h0F0F0F0F, 1'b0);
    send_vertex(32767, 32767, 32'hF0F0F0F0, 1'b0);
    send_vertex(0, 0, 32'h33333333, 1'b0);
    send_vertex(-32768, 32767, 32'hCCCCCCCC, 1'b0);
    send_vertex(1, 0, 32'h99999999, 1'b1);
    wait_drained();

    program_gradient(32767, -32768, -32768, 32767, 32'hFFFFFFFF, 32'h00000000, 1'b0);
    send_vertex(32767, -32768, 32'hFFFFFFFF, 1'b0);
    send_vertex(-32768, 32767, 32'h00000000, 1'b0);
    send_vertex(0, -1, 32'h7FFFFFFF, 1'b0);
    send_vertex(-100, 100, 32'h80000000, 1'b0);
    send_vertex(32767, 32767, 32'h00FFFFFF, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      random_gradient();
      tx_idle = (ph != 1) && (ph != 4);
      rx_idle = (ph != 1) && (ph != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == 50) begin
          hold_req = 1'b1;
          tx_idle  = 1'b0;
        end
        if (ph == 2 && i == 110) tx_idle = 1'b1;
        if (ph == 3 && i == 95) wait_drained();
        random_vertex();
      end
      wait_drained();
    end

    repeat (2 * LATENCY + 8) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/lgvs_pkg.sv
sv/lgvs_proj.sv
sv/lgvs_div.sv
sv/lgvs_blend.sv
sv/linear_gradient_vertex_shade.sv
verif/gradient_shade_checker.sv
verif/tb.sv
